// ===== rtl/insertion_ordered_key_value_map_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the insertion-ordered key-value map
// Concurrent assertion helpers shared by the RTL; defining ASSERT_OFF
// removes them.
// ----------------------------------------------------------------------------
`ifndef INSERTION_ORDERED_KEY_VALUE_MAP_DEFINES_SVH
`define INSERTION_ORDERED_KEY_VALUE_MAP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold on every clock edge outside reset.
`define IOKVM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Implication checked on every clock edge outside reset.
`define IOKVM_ASSERT_IMPL(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);
`else
`define IOKVM_ASSERT(name, clk, rst_n, prop, msg)
`define IOKVM_ASSERT_IMPL(name, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== rtl/iokvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered key-value map package
// Field widths, operation and status codes, and the control word of the
// transaction token that walks the cell chain.
// ----------------------------------------------------------------------------
package iokvm_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_GET  = 3'd0,
    OP_PUT  = 3'd1,
    OP_DEL  = 3'd2,
    OP_PREV = 3'd3,
    OP_NEXT = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // hit: lookup resolved (found, updated or inserted); del: a deletion has
  // taken place upstream and the cells behind it close the gap.
  typedef struct packed {
    logic valid;
    op_e  op;
    logic hit;
    logic del;
  } tok_ctrl_t;

endpackage

// ===== rtl/iokvm_if.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered key-value map channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface iokvm_req_if import iokvm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink (input valid, input operation, input key, input value, output ready);
endinterface

interface iokvm_rsp_if import iokvm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink (input valid, input status, input result_value, output ready);
endinterface

// ===== rtl/iokvm_cell.sv =====
// ----------------------------------------------------------------------------
// Map cell
// Holds one entry of the map and handles the token passing through it,
// then hands the token on to the next cell. Live entries are kept packed
// at the front of the chain in insertion order.
// ----------------------------------------------------------------------------
module iokvm_cell import iokvm_pkg::*; #(
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tok_ctrl_t             tok_ctrl_i,
  input  logic [KEY_BITS-1:0]   tok_key_i,
  input  logic [VALUE_BITS-1:0] tok_value_i,
  input  logic [VALUE_BITS-1:0] tok_result_i,
  output tok_ctrl_t             tok_ctrl_o,
  output logic [KEY_BITS-1:0]   tok_key_o,
  output logic [VALUE_BITS-1:0] tok_value_o,
  output logic [VALUE_BITS-1:0] tok_result_o,
  input  logic                  left_used_i,
  input  logic [VALUE_BITS-1:0] left_value_i,
  input  logic                  right_used_i,
  input  logic [KEY_BITS-1:0]   right_key_i,
  input  logic [VALUE_BITS-1:0] right_value_i,
  output logic                  used_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o
);

  logic                  used_q, used_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  tok_ctrl_t             ctrl_q, ctrl_d;
  logic [KEY_BITS-1:0]   tkey_q;
  logic [VALUE_BITS-1:0] tvalue_q;
  logic [VALUE_BITS-1:0] res_q, res_d;
  logic                  hit;

  assign hit = tok_ctrl_i.valid && used_q && (key_q == tok_key_i);

  always_comb begin
    ctrl_d  = tok_ctrl_i;
    res_d   = tok_result_i;
    used_d  = used_q;
    key_d   = key_q;
    value_d = value_q;
    if (tok_ctrl_i.valid) begin
      case (tok_ctrl_i.op)
        OP_GET: begin
          if (hit) begin
            ctrl_d.hit = 1'b1;
            res_d      = value_q;
          end
        end
        OP_PUT: begin
          // Live entries form a prefix, so the first free cell is only
          // reached once every live key has been compared.
          if (hit) begin
            value_d    = tok_value_i;
            ctrl_d.hit = 1'b1;
          end else if (!used_q && !tok_ctrl_i.hit) begin
            used_d     = 1'b1;
            key_d      = tok_key_i;
            value_d    = tok_value_i;
            ctrl_d.hit = 1'b1;
          end
        end
        OP_DEL: begin
          if (tok_ctrl_i.del) begin
            used_d = 1'b0;
          end else if (hit) begin
            used_d     = 1'b0;
            ctrl_d.del = 1'b1;
          end
        end
        OP_PREV: begin
          if (hit) begin
            ctrl_d.hit = left_used_i;
            if (left_used_i) begin
              res_d = left_value_i;
            end
          end
        end
        OP_NEXT: begin
          if (hit) begin
            ctrl_d.hit = right_used_i;
            if (right_used_i) begin
              res_d = right_value_i;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // The deleting token now sits in the next cell: pull its entry forward.
    if (ctrl_q.valid && ctrl_q.del) begin
      used_d  = right_used_i;
      key_d   = right_key_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      ctrl_q <= '0;
    end else begin
      used_q <= used_d;
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    value_q  <= value_d;
    tkey_q   <= tok_key_i;
    tvalue_q <= tok_value_i;
    res_q    <= res_d;
  end

  assign tok_ctrl_o   = ctrl_q;
  assign tok_key_o    = tkey_q;
  assign tok_value_o  = tvalue_q;
  assign tok_result_o = res_q;
  assign used_o       = used_q;
  assign key_o        = key_q;
  assign value_o      = value_q;

endmodule

// ===== rtl/insertion_ordered_key_value_map.sv =====
// ----------------------------------------------------------------------------
// Insertion-ordered key-value map
// Chain of entry cells with a token that carries each transaction through
// it, and a two-deep response buffer.
// ----------------------------------------------------------------------------
// Each request travels down a row of ENTRIES cells, one cell per cycle, and
// every cell compares, updates or shifts its own entry as the token passes.
// Live entries are kept packed at the front of the row in insertion order, so
// a delete closes the gap behind it and previous/next simply read the
// adjacent cell. The next request is accepted only once the token of the
// previous one has left the cell row, and then only while the response
// buffer has room. Up to two responses are buffered, so a request is still
// taken while one response waits. Only the low KEY_BITS of a key and the
// low VALUE_BITS of a value are used; returned values are zero-extended.
`include "insertion_ordered_key_value_map_defines.svh"

module insertion_ordered_key_value_map import iokvm_pkg::*; #(
  parameter int unsigned ENTRIES    = 256,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  iokvm_req_if.sink   req_i,
  iokvm_rsp_if.source rsp_o
);

  tok_ctrl_t             link_ctrl   [ENTRIES+1];
  logic [KEY_BITS-1:0]   link_key    [ENTRIES+1];
  logic [VALUE_BITS-1:0] link_value  [ENTRIES+1];
  logic [VALUE_BITS-1:0] link_result [ENTRIES+1];

  logic                  cell_used  [ENTRIES];
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];

  logic [ENTRIES-1:0]    used_vec;
  logic [ENTRIES-1:0]    tok_valid_vec;
  logic                  prefix_ok;

  logic                  in_accept;
  logic                  chain_busy_q;

  tok_ctrl_t             tail;
  logic                  push;
  logic                  pop;
  status_e               push_status;
  logic [VALUE_BITS-1:0] push_value;

  status_e               buf_status_q [2];
  logic [VALUE_BITS-1:0] buf_value_q  [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            cnt_q;

  assign req_i.ready = !chain_busy_q && (cnt_q != 2'd2);
  assign in_accept   = req_i.valid && req_i.ready;

  assign link_ctrl[0]   = '{valid: in_accept, op: op_e'(req_i.operation),
                            hit: 1'b0, del: 1'b0};
  assign link_key[0]    = KEY_BITS'(req_i.key);
  assign link_value[0]  = VALUE_BITS'(req_i.value);
  assign link_result[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                  left_used;
    logic [VALUE_BITS-1:0] left_value;
    logic                  right_used;
    logic [KEY_BITS-1:0]   right_key;
    logic [VALUE_BITS-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_used  = 1'b0;
      assign left_value = '0;
    end else begin : g_mid_l
      assign left_used  = cell_used[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right_used  = 1'b0;
      assign right_key   = '0;
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_used  = cell_used[i+1];
      assign right_key   = cell_key[i+1];
      assign right_value = cell_value[i+1];
    end

    iokvm_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .tok_ctrl_i    (link_ctrl[i]),
      .tok_key_i     (link_key[i]),
      .tok_value_i   (link_value[i]),
      .tok_result_i  (link_result[i]),
      .tok_ctrl_o    (link_ctrl[i+1]),
      .tok_key_o     (link_key[i+1]),
      .tok_value_o   (link_value[i+1]),
      .tok_result_o  (link_result[i+1]),
      .left_used_i   (left_used),
      .left_value_i  (left_value),
      .right_used_i  (right_used),
      .right_key_i   (right_key),
      .right_value_i (right_value),
      .used_o        (cell_used[i]),
      .key_o         (cell_key[i]),
      .value_o       (cell_value[i])
    );

    assign used_vec[i]      = cell_used[i];
    assign tok_valid_vec[i] = link_ctrl[i+1].valid;
  end

  assign tail = link_ctrl[ENTRIES];

  always_comb begin
    push        = 1'b0;
    push_status = ST_NONE;
    push_value  = '0;
    if (tail.valid) begin
      case (tail.op)
        OP_GET, OP_PREV, OP_NEXT: begin
          push = 1'b1;
          if (tail.hit) begin
            push_status = ST_FOUND;
            push_value  = link_result[ENTRIES];
          end
        end
        OP_PUT: begin
          push        = !tail.hit;
          push_status = ST_FULL;
        end
        default: begin
        end
      endcase
    end
  end

  assign pop = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_busy_q <= 1'b0;
      wr_ptr_q     <= 1'b0;
      rd_ptr_q     <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      if (in_accept) begin
        chain_busy_q <= 1'b1;
      end else if (tail.valid) begin
        chain_busy_q <= 1'b0;
      end
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_status_q[wr_ptr_q] <= push_status;
      buf_value_q[wr_ptr_q]  <= push_value;
    end
  end

  assign rsp_o.valid        = (cnt_q != 2'd0);
  assign rsp_o.status       = buf_status_q[rd_ptr_q];
  assign rsp_o.result_value = VALUE_W'(buf_value_q[rd_ptr_q]);

  assign prefix_ok = ((used_vec + ENTRIES'(1)) & used_vec) == '0;

  // Between transactions the live entries must sit packed at the front.
  `IOKVM_ASSERT_IMPL(a_prefix_packed, clk_i, rst_ni, !chain_busy_q, prefix_ok, "entries not packed")
  // At most one token is ever in flight along the chain.
  `IOKVM_ASSERT(a_single_token, clk_i, rst_ni, $onehot0(tok_valid_vec), "two tokens in flight")
  // A token leaving the chain always finds room in the response buffer.
  `IOKVM_ASSERT_IMPL(a_buf_room, clk_i, rst_ni, push && !pop, cnt_q != 2'd2, "buffer overflow")

endmodule

// ===== tb/insertion_ordered_key_value_map_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion-ordered key-value map testbench
// Drives get, put, delete, previous and next requests into the map. A local
// model of the slot store and its insertion-order links predicts every
// response, and the monitor checks each one field by field. Directed
// requests come first, then random traffic in four idling phases that fill,
// churn and drain the table, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module insertion_ordered_key_value_map_tb;
  import iokvm_pkg::*;

  localparam int MAP_ENTRIES    = 256;
  localparam int NULL_LINK      = MAP_ENTRIES;
  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 6;
  localparam int KEY_POOL_SIZE  = 300;
  localparam int PHASE_ITEMS    = 470;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 2 * (MAP_ENTRIES + 1) + 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {
    MODE_STEADY,
    MODE_SRC_IDLE,
    MODE_SNK_STALL,
    MODE_BOTH_IDLE
  } idle_mode_e;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    idle_mode_e         mode;
  } map_req_t;

  typedef struct {
    status_e            status;
    logic [VALUE_W-1:0] value;
  } map_rsp_t;

  // Percentages per idling mode, indexed by idle_mode_e.
  int src_idle_pct  [4] = '{0, 65, 0, 22};
  int snk_stall_pct [4] = '{0, 0, 65, 22};
  int put_weight    [4] = '{40, 60, 30, 40};
  int del_weight    [4] = '{15, 2, 30, 15};

  logic clk_i = 1'b0;
  logic rst_ni;

  iokvm_req_if req_if ();
  iokvm_rsp_if rsp_if ();

  insertion_ordered_key_value_map dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Local copy of the slot store.
  logic               slot_used  [MAP_ENTRIES];
  logic [KEY_W-1:0]   slot_key   [MAP_ENTRIES];
  logic [VALUE_W-1:0] slot_value [MAP_ENTRIES];
  int unsigned        slot_prev  [MAP_ENTRIES];
  int unsigned        slot_next  [MAP_ENTRIES];
  int unsigned        newest_slot;

  map_req_t   pending_req_q [$];
  map_rsp_t   expected_rsp_q [$];
  idle_mode_e offered_mode;
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

  int accepted_reqs;
  int rsp_count;
  int found_count;
  int none_count;
  int full_count;
  int ignored_count;
  int mismatch_count;
  int idle_cycles;
  int hold_left;
  bit hold_done;

  // Applies one request to the local store; returns 1 when it yields a response.
  function automatic bit apply_map_request(input logic [OP_W-1:0] op,
                                           input logic [KEY_W-1:0] key,
                                           input logic [VALUE_W-1:0] value,
                                           output map_rsp_t rsp);
    int unsigned hit;
    int unsigned slot;
    int unsigned nb;
    int unsigned p;
    int unsigned n;
    bit has_rsp;
    hit = NULL_LINK;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (hit == NULL_LINK && slot_used[i] && slot_key[i] == key) hit = i;
    end
    rsp.status = ST_NONE;
    rsp.value  = '0;
    has_rsp    = 1'b0;
    case (op)
      OP_GET: begin
        has_rsp = 1'b1;
        if (hit != NULL_LINK) begin
          rsp.status = ST_FOUND;
          rsp.value  = slot_value[hit];
        end
      end
      OP_PUT: begin
        if (hit != NULL_LINK) begin
          slot_value[hit] = value;
        end else begin
          slot = NULL_LINK;
          for (int i = 0; i < MAP_ENTRIES; i++) begin
            if (slot == NULL_LINK && !slot_used[i]) slot = i;
          end
          if (slot == NULL_LINK) begin
            has_rsp    = 1'b1;
            rsp.status = ST_FULL;
          end else begin
            slot_used[slot]  = 1'b1;
            slot_key[slot]   = key;
            slot_value[slot] = value;
            slot_prev[slot]  = newest_slot;
            slot_next[slot]  = NULL_LINK;
            if (newest_slot != NULL_LINK) slot_next[newest_slot] = slot;
            newest_slot = slot;
          end
        end
      end
      OP_DEL: begin
        if (hit != NULL_LINK) begin
          p = slot_prev[hit];
          n = slot_next[hit];
          if (p != NULL_LINK) slot_next[p] = n;
          if (n != NULL_LINK) slot_prev[n] = p;
          if (newest_slot == hit) newest_slot = p;
          slot_used[hit] = 1'b0;
        end
      end
      OP_PREV, OP_NEXT: begin
        has_rsp = 1'b1;
        if (hit != NULL_LINK) begin
          nb = (op == OP_PREV) ? slot_prev[hit] : slot_next[hit];
          if (nb != NULL_LINK && slot_used[nb]) begin
            rsp.status = ST_FOUND;
            rsp.value  = slot_value[nb];
          end
        end
      end
      default: ;
    endcase
    return has_rsp;
  endfunction

  function automatic void add_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                  input logic [VALUE_W-1:0] value, input idle_mode_e mode);
    map_req_t item;
    item.op    = op;
    item.key   = key;
    item.value = value;
    item.mode  = mode;
    pending_req_q.push_back(item);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Driver: a new transaction is offered only once the previous one has gone.
  always @(posedge clk_i) begin
    map_req_t item;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_req_q.size() > 0 &&
          $urandom_range(0, 99) >= src_idle_pct[pending_req_q[0].mode]) begin
        item = pending_req_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.operation <= item.op;
        req_if.key       <= item.key;
        req_if.value     <= item.value;
        offered_mode     <= item.mode;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the map up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && accepted_reqs >= HOLD_AT) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct[offered_mode]);
    end
  end

  // Monitor: checks responses, predicts from accepted requests, and keeps the watchdog.
  always @(posedge clk_i) begin
    map_rsp_t predicted;
    map_rsp_t oldest;
    bit req_fire;
    bit rsp_fire;
    if (rst_ni) begin
      req_fire = req_if.valid && req_if.ready;
      rsp_fire = rsp_if.valid && rsp_if.ready;
      if (rsp_fire) begin
        rsp_count++;
        if (expected_rsp_q.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("Unexpected response at %0t: status %0d value %h", $time,
                     rsp_if.status, rsp_if.result_value);
          mismatch_count++;
        end else begin
          oldest = expected_rsp_q.pop_front();
          case (oldest.status)
            ST_FOUND: found_count++;
            ST_NONE:  none_count++;
            default:  full_count++;
          endcase
          if (rsp_if.status !== oldest.status || rsp_if.result_value !== oldest.value) begin
            if (mismatch_count < MAX_REPORTS)
              $display("Mismatch at %0t: expected status %0d value %h, got status %0d value %h",
                       $time, oldest.status, oldest.value, rsp_if.status,
                       rsp_if.result_value);
            mismatch_count++;
          end
        end
      end
      if (req_fire) begin
        accepted_reqs++;
        if (req_if.operation > OP_NEXT) ignored_count++;
        if (apply_map_request(req_if.operation, req_if.key, req_if.value, predicted))
          expected_rsp_q.push_back(predicted);
      end
      if (req_fire || rsp_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles at %0t", idle_cycles, $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] k0, k1, k2, k3;
    logic [VALUE_W-1:0] v3;
    idle_mode_e mode;
    int r;
    int t;
    int u;
    logic [OP_W-1:0] op;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_GET;
    req_if.key       = '0;
    req_if.value     = '0;
    rsp_if.ready     = 1'b0;
    offered_mode     = MODE_STEADY;
    accepted_reqs    = 0;
    rsp_count        = 0;
    found_count      = 0;
    none_count       = 0;
    full_count       = 0;
    ignored_count    = 0;
    mismatch_count   = 0;
    idle_cycles      = 0;
    for (int i = 0; i < MAP_ENTRIES; i++) slot_used[i] = 1'b0;
    newest_slot = NULL_LINK;

    // Directed: empty table, head and tail neighbours, in-place update,
    // middle and tail deletion, deletion of an absent key, unused codes.
    k0 = '0;
    k1 = '1;
    k2 = 64'h5a5a_5a5a_a5a5_a5a5;
    k3 = 64'h0123_4567_89ab_cdef;
    v3 = rand64();
    add_req(OP_GET,  k0, rand64(), MODE_STEADY);
    add_req(OP_PREV, k1, rand64(), MODE_STEADY);
    add_req(OP_NEXT, k1, rand64(), MODE_STEADY);
    add_req(OP_DEL,  k0, rand64(), MODE_STEADY);
    add_req(OP_PUT,  k0, '1, MODE_STEADY);
    add_req(OP_PUT,  k1, '0, MODE_STEADY);
    add_req(OP_PUT,  k2, 64'ha5a5_a5a5_5a5a_5a5a, MODE_STEADY);
    add_req(OP_GET,  k0, '0, MODE_STEADY);
    add_req(OP_GET,  k1, '1, MODE_STEADY);
    add_req(OP_PREV, k0, '0, MODE_STEADY);
    add_req(OP_NEXT, k0, '0, MODE_STEADY);
    add_req(OP_PREV, k2, '0, MODE_STEADY);
    add_req(OP_NEXT, k2, '0, MODE_STEADY);
    add_req(OP_PUT,  k0, 64'h0000_0000_0000_1234, MODE_STEADY);
    add_req(OP_PREV, k1, '0, MODE_STEADY);
    add_req(OP_DEL,  k1, '0, MODE_STEADY);
    add_req(OP_NEXT, k0, '0, MODE_STEADY);
    add_req(OP_PREV, k2, '0, MODE_STEADY);
    add_req(OP_GET,  k1, '0, MODE_STEADY);
    add_req(OP_DEL,  k2, '0, MODE_STEADY);
    add_req(OP_PUT,  k3, v3, MODE_STEADY);
    add_req(OP_PREV, k3, '0, MODE_STEADY);
    for (int c = OP_NEXT + 1; c < (1 << OP_W); c++) add_req(OP_W'(c), k0, rand64(), MODE_STEADY);
    add_req(OP_GET,  k0, '0, MODE_STEADY);

    // Random traffic on a key pool a little larger than the table, so that
    // the phase with heavy puts fills it and the phase with heavy deletes
    // drains it again.
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = rand64();
    for (int ph = 0; ph < 4; ph++) begin
      mode = idle_mode_e'(ph);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          add_req(OP_W'($urandom_range(0, (1 << OP_W) - 1)), rand64(), rand64(), mode);
        end else begin
          t = $urandom_range(0, 99);
          if (t < put_weight[ph]) begin
            op = OP_PUT;
          end else if (t < put_weight[ph] + del_weight[ph]) begin
            op = OP_DEL;
          end else begin
            u = $urandom_range(0, 9);
            if (u < 3) op = OP_GET;
            else if (u < 6) op = OP_PREV;
            else if (u < 9) op = OP_NEXT;
            else op = OP_NEXT + OP_W'($urandom_range(1, 3));
          end
          add_req(op, key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)], rand64(), mode);
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_req_q.size() > 0 || req_if.valid) @(posedge clk_i);
    while (expected_rsp_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d with unused codes) and %0d responses:", accepted_reqs,
             ignored_count, rsp_count);
    $display("  %0d found, %0d none, %0d table full; %0d mismatches", found_count, none_count,
             full_count, mismatch_count);
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
